// ----- rtl/ldst_pkg.sv -----
// Shared constants, types and status codes for the linear drift significance test.
// Depends on nothing; used by ldst_arith and the top level.
`default_nettype none
package ldst_pkg;
  localparam int MaxPointsDefault  = 1024;
  localparam int SampleBitsDefault = 24;
  localparam int FracBitsDefault   = 12;

  localparam logic [15:0] ThresholdReset = 16'd768;
  localparam logic [10:0] MinPointsReset = 11'd4;

  localparam logic [0:0] RegThreshold = 1'b0;
  localparam logic [0:0] RegMinPoints = 1'b1;

  typedef enum logic [2:0] {
    StatusNoDrift    = 3'd0,
    StatusDrift      = 3'd1,
    StatusTooFew     = 3'd2,
    StatusDegenerate = 3'd3,
    StatusOverflow   = 3'd4
  } status_t;

  // Operation requested from the shared arithmetic unit.
  typedef enum logic [1:0] {
    OpMul  = 2'd0,
    OpDiv  = 2'd1,
    OpSqrt = 2'd2
  } arith_op_t;

  // Request and response between the fit sequencer and the arithmetic unit.
  typedef struct packed {
    logic      go;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic done;
  } arith_rsp_t;

  localparam int WideBits = 256;
endpackage
`default_nettype wire

// ----- rtl/ldst_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module ldst_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/ldst_arith.sv -----
// Shared multi-cycle unit: shift-add multiply, restoring divide and integer
// square root on unsigned 256-bit operands, one bit per cycle. Uses ldst_pkg.
`default_nettype none
module ldst_arith (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ldst_pkg::arith_req_t           req,
  input  wire logic [ldst_pkg::WideBits-1:0] opa,
  input  wire logic [ldst_pkg::WideBits-1:0] opb,
  output ldst_pkg::arith_rsp_t                rsp,
  output logic      [ldst_pkg::WideBits-1:0] res
);
  localparam int W = ldst_pkg::WideBits;

  typedef enum logic [1:0] {Idle, RunMul, RunDiv, RunSqrt} state_t;

  state_t       state;
  logic [8:0]   cnt;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] acc;
  logic [W-1:0] rem;
  logic [W-1:0] rem_sh;
  logic [W-1:0] sq_bit;
  logic [W-1:0] sq_try;

  assign rem_sh = {rem[W-2:0], a[W-1]};
  assign sq_try = acc + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= Idle;
      rsp.done <= 1'b0;
    end else begin
      // The last step of every operation runs with cnt at one.
      rsp.done <= (state != Idle) && (cnt == 9'd1);
      case (state)
        Idle: begin
          if (req.go) begin
            a      <= opa;
            b      <= opb;
            acc    <= '0;
            rem    <= '0;
            cnt    <= (req.op == ldst_pkg::OpSqrt) ? 9'd32 : 9'(W);
            sq_bit <= W'(1) << 62;
            case (req.op)
              ldst_pkg::OpMul:  state <= RunMul;
              ldst_pkg::OpDiv:  state <= RunDiv;
              ldst_pkg::OpSqrt: state <= RunSqrt;
              default:          state <= Idle;
            endcase
          end
        end
        RunMul: begin
          // Low-to-high shift-add, result kept modulo 2^W.
          if (b[0]) acc <= acc + a;
          a   <= a << 1;
          b   <= b >> 1;
          cnt <= cnt - 9'd1;
          if (cnt == 9'd1) begin
            state <= Idle;
            res   <= b[0] ? acc + a : acc;
          end
        end
        RunDiv: begin
          a <= {a[W-2:0], 1'b0};
          if (rem_sh >= b) begin
            rem <= rem_sh - b;
            acc <= {acc[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            acc <= {acc[W-2:0], 1'b0};
          end
          cnt <= cnt - 9'd1;
          if (cnt == 9'd1) begin
            state <= Idle;
            res   <= {acc[W-2:0], (rem_sh >= b)};
          end
        end
        RunSqrt: begin
          if (a >= sq_try) begin
            a   <= a - sq_try;
            acc <= (acc >> 1) + sq_bit;
          end else begin
            acc <= acc >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt - 9'd1;
          if (cnt == 9'd1) begin
            state <= Idle;
            res   <= (a >= sq_try) ? (acc >> 1) + sq_bit : acc >> 1;
          end
        end
        default: state <= Idle;
      endcase
    end
  end

  a_done_from_run: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(state) != Idle) else $error("done without a running operation");
  a_no_go_busy: assert property (@(posedge clk) disable iff (rst)
    (state != Idle) |=> !rsp.done || state == Idle) else $error("done left unit busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("done held longer than one cycle");
endmodule
`default_nettype wire

// ----- rtl/linear_drift_significance_test.sv -----
// Top level of the linear drift significance test: sample capture, the value
// memory and the fit sequencer. Uses ldst_pkg, ldst_ram and ldst_arith.
//
// Usage. Samples arrive on time_sample / value_sample with last_sample, and a
// request is taken at a clock edge where start is high and busy is low. Each
// ordinary sample is accepted in the Idle state, and in the Accum state its
// terms go into the running sums through two 24x24 multipliers. The value
// is written to the value memory at the address sample_count.
// The request carrying last_sample starts the fit. The fit runs the sum terms
// and the ratios through one shared unit that handles one bit per cycle, then
// reads the value memory once per stored sample for the sum of squares, one
// entry per cycle. A full fit runs fewer steps when no drift is found or the
// significance saturates; an overflow or too-few status goes from FitCheck
// straight to Emit. Busy stays high throughout. The result appears for
// exactly one cycle with result_valid high; the receiver cannot stall it.
// Configuration writes (cfg_valid/cfg_ready) are always taken; they must
// only be made while the block is idle.
// Reset clears the series state and loads the register defaults. The memory
// needs no clearing: only entries written in the current series are read.
`default_nettype none
module linear_drift_significance_test #(
  parameter int MAX_POINTS  = ldst_pkg::MaxPointsDefault,
  parameter int SAMPLE_BITS = ldst_pkg::SampleBitsDefault,
  parameter int FRAC_BITS   = ldst_pkg::FracBitsDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [SAMPLE_BITS-1:0] time_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] value_sample,
  input  wire logic                   last_sample,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  output logic                        result_valid,
  output logic [2:0]                  fit_status,
  output logic signed [31:0]          drift_slope,
  output logic signed [31:0]          fit_intercept,
  output logic [31:0]                 drift_significance,
  output logic [15:0]                 drift_confidence
);
  localparam int W  = ldst_pkg::WideBits;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * SAMPLE_BITS;

  typedef enum logic [4:0] {
    Idle, Accum, FitCheck, MulA, MulB, SubD, MulC, MulE, SubN, MulF, MulG, SubA,
    DivSlope, DivIcpt, SqRead, SqAcc, MulH, MulI, SubE, MulJ, MulK, SubQ, MulL,
    MulM, DivSig, SqrtSig, Conf, DivConf, Emit
  } state_t;

  state_t state;
  logic [15:0] threshold;
  logic [10:0] point_floor;
  logic [CW-1:0] sample_count;
  logic overflow_flag;
  logic signed [63:0] time_total, value_total, tsq_total, cross_total;
  logic signed [SAMPLE_BITS-1:0] t_q, v_q;
  logic last_q;
  logic [CW-1:0] rd_idx;
  logic rd_valid;
  logic [63:0] svv;

  // Signed big numbers as magnitude plus sign; 256-bit width.
  logic [W-1:0] mag_x, mag_y, mag_d, mag_nxy, mag_a, mag_q, tmp;
  logic neg_x, neg_y, neg_nxy, neg_a, neg_e, neg_q;
  logic pneg;
  logic [31:0] sig;

  ldst_pkg::arith_req_t areq;
  ldst_pkg::arith_rsp_t arsp;
  logic [W-1:0] opa, opb, ares;

  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [SAMPLE_BITS-1:0] v_rd;

  logic signed [PW-1:0] prod_tt, prod_tv, prod_vv;

  ldst_ram #(.Width(SAMPLE_BITS), .Depth(MAX_POINTS)) u_value_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(v_q), .rdata(v_rd));

  ldst_arith u_arith (.clk(clk), .rst(rst), .req(areq), .opa(opa), .opb(opb),
    .rsp(arsp), .res(ares));

  assign mem_we   = (state == Accum) && !overflow_flag && (sample_count < CW'(MAX_POINTS));
  assign mem_addr = (state == SqRead || state == SqAcc) ? rd_idx[AW-1:0]
                                                        : sample_count[AW-1:0];
  assign prod_tt  = PW'(t_q) * PW'(t_q);
  assign prod_tv  = PW'(t_q) * PW'(v_q);
  assign prod_vv  = PW'($signed(v_rd)) * PW'($signed(v_rd));
  assign busy      = (state != Idle);
  assign cfg_ready = 1'b1;

  function automatic logic [W-1:0] absw(input logic signed [63:0] x);
    logic [63:0] u;
    u = x[63] ? 64'(-x) : 64'(x);
    return W'(u);
  endfunction

  // Signed subtract of magnitude/sign pairs: (ma,na) - (mb,nb).
  function automatic logic [W:0] ssub(input logic [W-1:0] ma, input logic na,
                                      input logic [W-1:0] mb, input logic nb);
    logic [W-1:0] m;
    logic n;
    logic nbi;
    nbi = !nb;
    if (na == nbi) begin
      m = ma + mb; n = na;
    end else if (ma >= mb) begin
      m = ma - mb; n = na;
    end else begin
      m = mb - ma; n = nbi;
    end
    if (m == '0) n = 1'b0;
    return {n, m};
  endfunction

  // Saturate and sign a quotient from ares to 32 bits; rounding is done in the divide.
  function automatic logic [31:0] rsat(input logic [W-1:0] q, input logic n);
    logic [31:0] lim;
    logic [31:0] v;
    lim = n ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v = q[31:0];
    if (q[W-1:32] != '0 || v > lim) v = lim;
    return n ? 32'(-v) : v;
  endfunction

  logic [W:0] sub_r;
  always_comb begin
    sub_r = ssub(mag_x, neg_x, mag_y, neg_y);
  end

  always_comb begin
    areq.go = 1'b0;
    areq.op = ldst_pkg::OpMul;
    opa = mag_x;
    opb = mag_y;
    case (state)
      MulA, MulB, MulC, MulE, MulF, MulG, MulH, MulI, MulJ, MulK, MulL, MulM:
        areq.go = !pneg;
      DivSlope, DivIcpt, DivSig, DivConf: begin
        areq.go = !pneg;
        areq.op = ldst_pkg::OpDiv;
      end
      SqrtSig: begin
        areq.go = !pneg;
        areq.op = ldst_pkg::OpSqrt;
      end
      default: areq.go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= Idle;
      threshold     <= ldst_pkg::ThresholdReset;
      point_floor   <= ldst_pkg::MinPointsReset;
      sample_count  <= '0;
      overflow_flag <= 1'b0;
      time_total    <= '0;
      value_total   <= '0;
      tsq_total     <= '0;
      cross_total   <= '0;
      result_valid  <= 1'b0;
      pneg          <= 1'b0;
    end else begin
      result_valid <= (state == Emit);
      if (cfg_valid) begin
        if (cfg_index == ldst_pkg::RegThreshold) threshold <= cfg_data;
        else point_floor <= cfg_data[10:0];
      end
      case (state)
        Idle: begin
          if (start) begin
            t_q    <= time_sample;
            v_q    <= value_sample;
            last_q <= last_sample;
            state  <= Accum;
          end
        end
        Accum: begin
          if (mem_we) begin
            time_total   <= time_total + 64'(t_q);
            value_total  <= value_total + 64'(v_q);
            tsq_total    <= tsq_total + 64'(prod_tt);
            cross_total  <= cross_total + 64'(prod_tv);
            sample_count <= sample_count + CW'(1);
          end else begin
            overflow_flag <= 1'b1;
          end
          state <= last_q ? FitCheck : Idle;
        end
        FitCheck: begin
          drift_slope        <= '0;
          fit_intercept      <= '0;
          drift_significance <= '0;
          drift_confidence   <= '0;
          if (overflow_flag) begin
            fit_status <= ldst_pkg::StatusOverflow;
            state      <= Emit;
          end else if (32'(sample_count) < 32'(point_floor) || sample_count < CW'(3)) begin
            fit_status <= ldst_pkg::StatusTooFew;
            state      <= Emit;
          end else begin
            fit_status <= ldst_pkg::StatusNoDrift;
            // n * Stt
            mag_x <= W'(sample_count); neg_x <= 1'b0;
            mag_y <= absw(tsq_total);  neg_y <= 1'b0;
            state <= MulA;
          end
        end
        default: begin
          // Remaining states; the arithmetic ones issue once, then wait for done.
          if (arsp.done) pneg <= 1'b0;
          else if (areq.go) pneg <= 1'b1;
          case (state)
            MulA: if (arsp.done) begin
              tmp <= ares;
              mag_x <= absw(time_total); neg_x <= 1'b0;
              mag_y <= absw(time_total); neg_y <= 1'b0;
              state <= MulB;
            end
            MulB: if (arsp.done) begin
              mag_x <= tmp; neg_x <= 1'b0;
              mag_y <= ares; neg_y <= 1'b0;
              state <= SubD;
            end
            SubD: begin
              mag_d <= sub_r[W-1:0];
              if (sub_r[W-1:0] == '0 || sub_r[W]) begin
                fit_status <= ldst_pkg::StatusDegenerate;
                state <= Emit;
              end else begin
                mag_x <= W'(sample_count); neg_x <= 1'b0;
                mag_y <= absw(cross_total); neg_y <= cross_total[63];
                state <= MulC;
              end
            end
            MulC: if (arsp.done) begin
              tmp <= ares; neg_q <= neg_y && ares != '0;
              mag_x <= absw(time_total); mag_y <= absw(value_total);
              neg_x <= (time_total[63] != value_total[63]);
              state <= MulE;
            end
            MulE: if (arsp.done) begin
              mag_y <= ares; neg_y <= neg_x && ares != '0;
              mag_x <= tmp; neg_x <= neg_q;
              state <= SubN;
            end
            SubN: begin
              mag_nxy <= sub_r[W-1:0]; neg_nxy <= sub_r[W];
              mag_x <= absw(tsq_total); mag_y <= absw(value_total);
              neg_x <= value_total[63];
              state <= MulF;
            end
            MulF: if (arsp.done) begin
              tmp <= ares; neg_q <= neg_x && ares != '0;
              mag_x <= absw(time_total); mag_y <= absw(cross_total);
              neg_x <= (time_total[63] != cross_total[63]);
              state <= MulG;
            end
            MulG: if (arsp.done) begin
              mag_y <= ares; neg_y <= neg_x && ares != '0;
              mag_x <= tmp; neg_x <= neg_q;
              state <= SubA;
            end
            SubA: begin
              mag_a <= sub_r[W-1:0]; neg_a <= sub_r[W];
              // Slope: (2*nxy*2^16 + d) / (2*d).
              mag_x <= (mag_nxy << 17) + mag_d;
              mag_y <= mag_d << 1;
              state <= DivSlope;
            end
            DivSlope: if (arsp.done) begin
              drift_slope <= rsat(ares, neg_nxy);
              mag_x <= (mag_a << 17) + (mag_d << FRAC_BITS);
              mag_y <= mag_d << (FRAC_BITS + 1);
              state <= DivIcpt;
            end
            DivIcpt: if (arsp.done) begin
              fit_intercept <= rsat(ares, neg_a);
              svv <= '0; rd_idx <= '0; rd_valid <= 1'b0;
              state <= SqRead;
            end
            SqRead: begin
              // Read one entry per cycle; accumulate the previous read.
              if (rd_valid) svv <= svv + 64'(prod_vv);
              if (rd_idx == sample_count) begin
                state <= SqAcc;
              end else begin
                rd_idx <= rd_idx + CW'(1);
              end
              rd_valid <= (rd_idx != sample_count);
            end
            SqAcc: begin
              mag_x <= W'(sample_count); neg_x <= 1'b0;
              mag_y <= W'(svv); neg_y <= 1'b0;
              state <= MulH;
            end
            MulH: if (arsp.done) begin
              tmp <= ares;
              mag_x <= absw(value_total); mag_y <= absw(value_total);
              state <= MulI;
            end
            MulI: if (arsp.done) begin
              mag_x <= tmp; neg_x <= 1'b0;
              mag_y <= ares; neg_y <= 1'b0;
              state <= SubE;
            end
            SubE: begin
              neg_e <= sub_r[W];
              mag_x <= sub_r[W-1:0]; mag_y <= mag_d;
              state <= MulJ;
            end
            MulJ: if (arsp.done) begin
              tmp <= ares; neg_q <= neg_e && ares != '0;
              mag_x <= mag_nxy; mag_y <= mag_nxy;
              state <= MulK;
            end
            MulK: if (arsp.done) begin
              mag_x <= tmp; neg_x <= neg_q;
              mag_y <= ares; neg_y <= 1'b0;
              state <= SubQ;
            end
            SubQ: begin
              mag_q <= sub_r[W-1:0]; neg_q <= sub_r[W];
              if (mag_nxy == '0) begin
                sig <= '0; state <= Conf;
              end else if (sub_r[W-1:0] == '0 || sub_r[W]) begin
                sig <= '1; state <= Conf;
              end else begin
                mag_x <= mag_nxy; mag_y <= mag_nxy;
                state <= MulL;
              end
            end
            MulL: if (arsp.done) begin
              mag_x <= ares; mag_y <= W'(sample_count - CW'(2));
              state <= MulM;
            end
            MulM: if (arsp.done) begin
              mag_x <= ares << 32; mag_y <= mag_q;
              state <= DivSig;
            end
            DivSig: if (arsp.done) begin
              if (ares[W-1:64] != '0) begin
                sig <= '1; state <= Conf;
              end else begin
                mag_x <= ares; state <= SqrtSig;
              end
            end
            SqrtSig: if (arsp.done) begin
              sig <= ares[31:0]; state <= Conf;
            end
            Conf: begin
              drift_significance <= sig;
              if (sig > {threshold, 8'd0}) begin
                fit_status <= ldst_pkg::StatusDrift;
                if (threshold == '0) begin
                  drift_confidence <= 16'h8000;
                  state <= Emit;
                end else begin
                  mag_x <= W'({sig, 6'd0}); mag_y <= W'(threshold);
                  state <= DivConf;
                end
              end else begin
                state <= Emit;
              end
            end
            DivConf: if (arsp.done) begin
              // Confidence is capped at 1.0.
              drift_confidence <= (ares > W'(32768)) ? 16'h8000 : ares[15:0];
              state <= Emit;
            end
            Emit: begin
              sample_count  <= '0;
              overflow_flag <= 1'b0;
              time_total    <= '0;
              value_total   <= '0;
              tsq_total     <= '0;
              cross_total   <= '0;
              state         <= Idle;
            end
            default: state <= Idle;
          endcase
        end
      endcase
    end
  end

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == Emit) else $error("result outside emit");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CW'(MAX_POINTS)) else $error("sample count beyond depth");
endmodule
`default_nettype wire

// ----- tb/linear_drift_significance_test_test.sv -----
// Self-checking testbench for the linear drift significance test.
// Depends on ldst_pkg and the linear_drift_significance_test top level.
// A scoreboard class predicts each fit result and checks the block's output.
module linear_drift_significance_test_test;

  localparam int LIMIT_CYCLES = 12000000;
  localparam int MAX_SAMPLES  = 1024;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    ldst_pkg::status_t status;
    logic [31:0] slope;
    logic [31:0] intercept;
    logic [31:0] significance;
    logic [15:0] confidence;
  } fit_result_t;

  class drift_scoreboard;
    fit_result_t    pending[$];
    int             errors;
    logic [15:0]    threshold;
    logic [10:0]    point_floor;
    int             count;
    longint         sum_t, sum_v, sum_tt, sum_tv;
    int             values[MAX_SAMPLES];
    bit             overflowed;

    function new();
      threshold   = ldst_pkg::ThresholdReset;
      point_floor = ldst_pkg::MinPointsReset;
      errors      = 0;
      clear();
    endfunction

    function void clear();
      count = 0;
      sum_t = 0;
      sum_v = 0;
      sum_tt = 0;
      sum_tv = 0;
      overflowed = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [15:0] data);
      if (idx == ldst_pkg::RegThreshold) threshold = data;
      else point_floor = data[10:0];
    endfunction

    function logic [31:0] round_sat(wide_t mag, bit neg, wide_t den);
      wide_t q;
      wide_t lim;
      q = ((mag <<< 1) + den) / (den <<< 1);
      lim = neg ? 256'sh8000_0000 : 256'sh7FFF_FFFF;
      if (q > lim) q = lim;
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function logic [31:0] isqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'h1 << 62;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[31:0];
    endfunction

    function fit_result_t fit();
      fit_result_t r;
      wide_t n, st, sv, stt, stv, d, nxy, a, e, q, num, quo, svv;
      logic [31:0] sig;
      logic [63:0] c;
      r = '{ldst_pkg::StatusNoDrift, 0, 0, 0, 0};
      if (overflowed) begin
        r.status = ldst_pkg::StatusOverflow;
        return r;
      end
      if (count < point_floor || count < 3) begin
        r.status = ldst_pkg::StatusTooFew;
        return r;
      end
      n = count; st = sum_t; sv = sum_v; stt = sum_tt; stv = sum_tv;
      d = n * stt - st * st;
      if (d <= 0) begin
        r.status = ldst_pkg::StatusDegenerate;
        return r;
      end
      nxy = n * stv - st * sv;
      a = stt * sv - st * stv;
      r.slope = round_sat((nxy < 0 ? -nxy : nxy) <<< 16, nxy < 0, d);
      r.intercept = round_sat((a < 0 ? -a : a) <<< 16, a < 0, d <<< 12);
      svv = 0;
      for (int i = 0; i < count; i++) svv += wide_t'(values[i]) * wide_t'(values[i]);
      e = n * svv - sv * sv;
      q = e * d - nxy * nxy;
      if (nxy == 0) begin
        sig = 0;
      end else if (q <= 0) begin
        sig = 32'hFFFF_FFFF;
      end else begin
        num = (nxy * nxy * (n - 2)) <<< 32;
        quo = num / q;
        if (quo[255:64] != 0) sig = 32'hFFFF_FFFF;
        else sig = isqrt(quo[63:0]);
      end
      r.significance = sig;
      if ({32'd0, sig} > ({48'd0, threshold} << 8)) begin
        if (threshold == 0) c = 32768;
        else c = ({32'd0, sig} << 6) / threshold;
        if (c > 32768) c = 32768;
        r.status = ldst_pkg::StatusDrift;
        r.confidence = c[15:0];
      end
      return r;
    endfunction

    function void note_sample(logic [23:0] t_raw, logic [23:0] v_raw, bit last);
      longint t, v;
      t = longint'(signed'(t_raw));
      v = longint'(signed'(v_raw));
      if (!overflowed && count < MAX_SAMPLES) begin
        values[count] = int'(v);
        sum_t += t;
        sum_v += v;
        sum_tt += t * t;
        sum_tv += t * v;
        count++;
      end else begin
        overflowed = 1;
      end
      if (last) begin
        pending.insert(pending.size(), fit());
        clear();
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_result(fit_result_t got);
      fit_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.status, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) report("fit_status", got.status, want.status);
      if (got.slope != want.slope) report("drift_slope", got.slope, want.slope);
      if (got.intercept != want.intercept)
        report("fit_intercept", got.intercept, want.intercept);
      if (got.significance != want.significance)
        report("drift_significance", got.significance, want.significance);
      if (got.confidence != want.confidence)
        report("drift_confidence", got.confidence, want.confidence);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic signed [23:0] time_sample = 0;
  logic signed [23:0] value_sample = 0;
  logic        last_sample = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic        result_valid;
  logic [2:0]  fit_status;
  logic signed [31:0] drift_slope, fit_intercept;
  logic [31:0] drift_significance;
  logic [15:0] drift_confidence;

  drift_scoreboard sb = new();
  bit          steady;
  int          cycles = 0;
  int          sent = 0;

  linear_drift_significance_test u_top (
    .clk, .rst, .start, .busy, .time_sample, .value_sample, .last_sample,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .result_valid, .fit_status,
    .drift_slope, .fit_intercept, .drift_significance, .drift_confidence
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("linear_drift_significance_test test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    fit_result_t got;
    if (!rst && result_valid) begin
      got.status = ldst_pkg::status_t'(fit_status);
      got.slope = drift_slope;
      got.intercept = fit_intercept;
      got.significance = drift_significance;
      got.confidence = drift_confidence;
      sb.check_result(got);
    end
  end

  // Issue one sample request and hold it until the block takes it.
  // Start stays high afterwards; the next call or wait_idle drives it.
  task send(logic [23:0] t, logic [23:0] v, bit last);
    while (!steady && $urandom_range(99) < 29) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    time_sample <= t;
    value_sample <= v;
    last_sample <= last;
    do @(posedge clk); while (busy);
    sb.note_sample(t, v, last);
    sent++;
  endtask

  task wait_idle();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_reg(logic [0:0] idx, logic [15:0] data);
    wait_idle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task random_series();
    int n, kind, t0, step, k, amp;
    logic [23:0] t, v;
    kind = $urandom_range(99);
    n = $urandom_range(3, 14);
    if (kind < 8) n = $urandom_range(1, 2);
    t0 = $urandom_range(0, 2097151) - 1048576;
    step = $urandom_range(1, 8192);
    k = $urandom_range(0, 64) - 32;
    amp = 1 << $urandom_range(0, 20);
    for (int i = 0; i < n; i++) begin
      if (kind < 20) begin
        t = 24'($urandom);
        v = 24'($urandom);
      end else if (kind < 28) begin
        t = 24'(t0);
        v = 24'($urandom);
      end else begin
        t = 24'(t0 + i * step);
        v = (kind < 36) ? 24'(k * (t0 + i * step) / 8)
                        : 24'(k * ((t0 + i * step) / 8) + $urandom_range(0, amp) - amp / 2);
      end
      send(t, v, i == n - 1);
    end
  endtask

  initial begin
    steady = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Extreme field values in one series.
    send(24'h7FFFFF, 24'h800000, 0);
    send(24'h800000, 24'h7FFFFF, 0);
    send(24'h000000, 24'h000000, 0);
    send(24'h7FFFFF, 24'h7FFFFF, 1);
    // Two points only, then identical times.
    send(24'h001000, 24'h000100, 0);
    send(24'h002000, 24'h000200, 1);
    for (int i = 0; i < 4; i++) send(24'h012345, 24'(24'h000100 * i), i == 3);
    // Perfect line, then a flat line.
    for (int i = 0; i < 5; i++) send(24'(24'h001000 * i), 24'(24'h002000 * i), i == 4);
    for (int i = 0; i < 4; i++) send(24'(24'h000800 * i), 24'h00ABCD, i == 3);
    write_reg(ldst_pkg::RegThreshold, 16'd0);
    for (int i = 0; i < 4; i++)
      send(24'(24'h000400 * i), 24'(24'h000100 * i + i * i), i == 3);
    write_reg(ldst_pkg::RegThreshold, 16'hFFFF);
    write_reg(ldst_pkg::RegMinPoints, 16'd1024);
    for (int i = 0; i < 4; i++) send(24'(24'h000400 * i), 24'(24'h000300 * i), i == 3);
    write_reg(ldst_pkg::RegMinPoints, 16'd0);
    write_reg(ldst_pkg::RegThreshold, ldst_pkg::ThresholdReset);

    while (sent < 850) begin
      steady = (sent > 300 && sent < 450);
      if ($urandom_range(19) == 0) begin
        if ($urandom_range(1))
          write_reg(ldst_pkg::RegThreshold,
                    $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 2000)));
        else
          write_reg(ldst_pkg::RegMinPoints,
                    $urandom_range(0, 3) == 0 ? 16'd1024 : 16'($urandom_range(0, 8)));
        if (sb.point_floor > 16) write_reg(ldst_pkg::RegMinPoints, 16'd3);
      end
      if (sent > 600 && sent < 650) wait_idle();
      random_series();
    end

    // A series past the buffer capacity.
    steady = 1;
    for (int i = 0; i < MAX_SAMPLES + 3; i++)
      send(24'($urandom), 24'($urandom), i == MAX_SAMPLES + 2);

    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("linear_drift_significance_test test passed");
    else $display("linear_drift_significance_test test failed");
    $finish;
  end
endmodule
